// ===== hdl/erd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erd_pkg: shared types and constants for the exclusion ring update core
// Transaction layouts, command and hop codes, configuration register indexes
// and the reset values of the configuration registers.
// ----------------------------------------------------------------------------
package erd_pkg;

  // Width of the site field and of the position registers seen at the ports.
  localparam int SITE_W = 9;
  localparam int RATE_W = 17;
  localparam int DRAW_W = 16;
  localparam int PERIOD_W = 16;
  localparam int CUR_W = 48;

  // Configuration port geometry.
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 17;

  // Command codes carried in the cmd field.
  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  // Hop codes reported in the hop field.
  localparam logic [1:0] HOP_NONE  = 2'd0;
  localparam logic [1:0] HOP_RIGHT = 2'd1;
  localparam logic [1:0] HOP_LEFT  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_RATE_CENTER       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_BULK         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_FAR_INWARD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_NEAR_OUTWARD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_NEAR_INWARD  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEFECT_PERIOD     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BOND_SITE         = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DEFECT_START      = 3'd7;

  // Reset values of the configuration registers.
  localparam logic [RATE_W-1:0]   RATE_CENTER_RST   = 17'd65536;
  localparam logic [PERIOD_W-1:0] DEFECT_PERIOD_RST = 16'd512;
  localparam logic [SITE_W-1:0]   BOND_SITE_RST     = 9'd27;
  localparam logic [SITE_W-1:0]   DEFECT_START_RST  = 9'd10;

  // Saturation limits of the net current.
  localparam logic signed [CUR_W-1:0] CUR_MAX = {1'b0, {(CUR_W-1){1'b1}}};
  localparam logic signed [CUR_W-1:0] CUR_MIN = {1'b1, {(CUR_W-1){1'b0}}};

  // One input transaction.
  typedef struct packed {
    logic [1:0]        cmd;
    logic [SITE_W-1:0] site;
    logic              occupy;
    logic              coin;
    logic [DRAW_W-1:0] draw;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    logic [1:0]              hop;
    logic signed [CUR_W-1:0] net_current;
    logic [SITE_W-1:0]       defect_pos;
  } out_item_t;

endpackage

// ===== hdl/erd_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erd_stream_if: valid/ready channel with a typed payload
// A transaction moves at a rising clock edge where valid and ready are high.
// ----------------------------------------------------------------------------
interface erd_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

// ===== hdl/exclusion_ring_defect_mc_step_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exclusion_ring_defect_mc_step_core: Monte Carlo update of a particle ring
// Hard-core particle ring with a moving defect, one load, update, clear or
// no-op command per transaction, one result transaction per command.
// ----------------------------------------------------------------------------
// The core takes one transaction per clock while the result side is ready
// and returns one result for each. A transaction is captured in an input
// register; from there the three occupancy bits around the chosen site are
// read from the flip-flop ring, the hop is decided and the ring, current,
// period count and defect position are updated at the same edge that loads
// the result register, so the following transaction always sees the state
// left by the one before. Occupancy, counters and defect position are ready
// right after reset; no clearing pass is needed. Configuration writes are
// taken at any edge where cfg_we is high and must only be issued while no
// transaction is in flight.
module exclusion_ring_defect_mc_step_core
  import erd_pkg::*;
#(
  parameter int RING_SITES = 512
) (
  input  logic                   clk,
  input  logic                   rst_n,
  erd_stream_if.sink             in_if,
  erd_stream_if.source           out_if,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_idx,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int SW = $clog2(RING_SITES);

  // Reduces a site-field value modulo the ring size by a short chain of
  // compare-and-subtract steps against doubled copies of the ring size.
  function automatic logic [SITE_W-1:0] wrap_site(input logic [SITE_W-1:0] v);
    logic [SITE_W-1:0] w;
    w = v;
    for (int k = 6; k >= 0; k--) begin
      if ((RING_SITES << k) < (1 << SITE_W) && 32'(w) >= (RING_SITES << k)) begin
        w = w - SITE_W'(RING_SITES << k);
      end
    end
    return w;
  endfunction

  // Configuration registers.
  logic [RATE_W-1:0]   rate_center_r;
  logic [RATE_W-1:0]   rate_bulk_r;
  logic [RATE_W-1:0]   rate_far_in_r;
  logic [RATE_W-1:0]   rate_near_out_r;
  logic [RATE_W-1:0]   rate_near_in_r;
  logic [PERIOD_W-1:0] period_r;
  logic [SW-1:0]       bond_r;
  logic [SW-1:0]       start_r;

  // Pipeline and state registers.
  logic                    s1_valid_r;
  in_item_t                s1_r;
  logic                    out_valid_r;
  out_item_t               out_r;
  logic [RING_SITES-1:0]   occ_r;
  logic [SW-1:0]           def_r;
  logic [PERIOD_W-1:0]     cnt_r;
  logic signed [CUR_W-1:0] cur_r;

  // Next values.
  logic [RING_SITES-1:0]   occ_nxt;
  logic [SW-1:0]           def_nxt;
  logic [PERIOD_W-1:0]     cnt_nxt;
  logic signed [CUR_W-1:0] cur_nxt;
  out_item_t               out_nxt;

  // Working signals of the update.
  logic            fire_s1;
  logic [SW-1:0]   b;
  logic [SW-1:0]   right;
  logic [SW-1:0]   left;
  logic [SW:0]     diff;
  logic [SW-1:0]   off;
  logic [SW-1:0]   bond_p1;
  logic [RATE_W-1:0] rr;
  logic [RATE_W-1:0] rl;
  logic            free_r;
  logic            free_l;
  logic            ok_r;
  logic            ok_l;
  logic [1:0]      hop;
  logic [PERIOD_W-1:0] cnt_inc;

  // Handshake: the input stage moves on whenever the result register is free.
  assign fire_s1     = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || fire_s1;
  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_r;

  // Ring neighbors, defect offset and the site after the bond.
  always_comb begin
    b       = SW'(wrap_site(s1_r.site));
    right   = (b == SW'(RING_SITES - 1)) ? '0 : b + SW'(1);
    left    = (b == '0) ? SW'(RING_SITES - 1) : b - SW'(1);
    diff    = {1'b0, b} - {1'b0, def_r};
    off     = diff[SW] ? SW'(diff + (SW+1)'(RING_SITES)) : diff[SW-1:0];
    bond_p1 = (bond_r == SW'(RING_SITES - 1)) ? '0 : bond_r + SW'(1);
  end

  // Rate selection by offset from the defect.
  always_comb begin
    rr = rate_bulk_r;
    rl = rate_bulk_r;
    priority if (off == '0) begin
      rr = rate_center_r;
      rl = rate_center_r;
    end else if (off == SW'(RING_SITES - 1)) begin
      rr = rate_near_in_r;
      rl = rate_near_out_r;
    end else if (off == SW'(RING_SITES - 2)) begin
      rr = rate_far_in_r;
    end else if (off == SW'(1)) begin
      rr = rate_near_out_r;
      rl = rate_near_in_r;
    end else if (off == SW'(2)) begin
      rl = rate_far_in_r;
    end else begin
      // Sites away from the defect use the bulk rate both ways.
      rr = rate_bulk_r;
      rl = rate_bulk_r;
    end
  end

  // Hop decision for an occupied chosen site.
  always_comb begin
    free_r = !occ_r[right];
    free_l = !occ_r[left];
    ok_r   = {1'b0, s1_r.draw} < rr;
    ok_l   = {1'b0, s1_r.draw} < rl;
    hop    = HOP_NONE;
    if (s1_r.cmd == CMD_UPDATE && occ_r[b]) begin
      priority if (free_r && free_l) begin
        if (s1_r.coin) begin
          hop = ok_r ? HOP_RIGHT : HOP_NONE;
        end else begin
          hop = ok_l ? HOP_LEFT : HOP_NONE;
        end
      end else if (free_r) begin
        hop = (s1_r.coin && ok_r) ? HOP_RIGHT : HOP_NONE;
      end else if (free_l) begin
        hop = (s1_r.coin && ok_l) ? HOP_LEFT : HOP_NONE;
      end else begin
        hop = HOP_NONE;
      end
    end
  end

  // State update for the command in the input register.
  always_comb begin
    occ_nxt = occ_r;
    def_nxt = def_r;
    cnt_nxt = cnt_r;
    cur_nxt = cur_r;
    cnt_inc = cnt_r + PERIOD_W'(1);
    unique case (cmd_t'(s1_r.cmd))
      CMD_LOAD: begin
        occ_nxt[b] = s1_r.occupy;
      end
      CMD_CLEAR: begin
        cur_nxt = '0;
        cnt_nxt = '0;
        def_nxt = start_r;
      end
      CMD_UPDATE: begin
        if (hop == HOP_RIGHT) begin
          occ_nxt[b]     = 1'b0;
          occ_nxt[right] = 1'b1;
          if (b == bond_r && cur_r != CUR_MAX) begin
            cur_nxt = cur_r + CUR_W'(1);
          end
        end else if (hop == HOP_LEFT) begin
          occ_nxt[b]    = 1'b0;
          occ_nxt[left] = 1'b1;
          if (b == bond_p1 && cur_r != CUR_MIN) begin
            cur_nxt = cur_r - CUR_W'(1);
          end
        end
        // Defect advances once every period updates.
        if (cnt_inc == period_r) begin
          cnt_nxt = '0;
          def_nxt = (def_r == SW'(RING_SITES - 1)) ? '0 : def_r + SW'(1);
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
      CMD_NONE: begin
      end
      default: begin
      end
    endcase
    out_nxt.hop         = hop;
    out_nxt.net_current = cur_nxt;
    out_nxt.defect_pos  = SITE_W'(def_nxt);
  end

  // Control, state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      occ_r           <= '0;
      def_r           <= SW'(wrap_site(DEFECT_START_RST));
      cnt_r           <= '0;
      cur_r           <= '0;
      rate_center_r   <= RATE_CENTER_RST;
      rate_bulk_r     <= '0;
      rate_far_in_r   <= '0;
      rate_near_out_r <= '0;
      rate_near_in_r  <= '0;
      period_r        <= DEFECT_PERIOD_RST;
      bond_r          <= SW'(wrap_site(BOND_SITE_RST));
      start_r         <= SW'(wrap_site(DEFECT_START_RST));
    end else begin
      if (in_if.ready) begin
        s1_valid_r <= in_if.valid;
      end
      if (fire_s1) begin
        out_valid_r <= 1'b1;
        occ_r       <= occ_nxt;
        def_r       <= def_nxt;
        cnt_r       <= cnt_nxt;
        cur_r       <= cur_nxt;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_RATE_CENTER:       rate_center_r   <= cfg_data[RATE_W-1:0];
          REG_RATE_BULK:         rate_bulk_r     <= cfg_data[RATE_W-1:0];
          REG_RATE_FAR_INWARD:   rate_far_in_r   <= cfg_data[RATE_W-1:0];
          REG_RATE_NEAR_OUTWARD: rate_near_out_r <= cfg_data[RATE_W-1:0];
          REG_RATE_NEAR_INWARD:  rate_near_in_r  <= cfg_data[RATE_W-1:0];
          REG_DEFECT_PERIOD:     period_r        <= cfg_data[PERIOD_W-1:0];
          REG_BOND_SITE:         bond_r  <= SW'(wrap_site(cfg_data[SITE_W-1:0]));
          REG_DEFECT_START:      start_r <= SW'(wrap_site(cfg_data[SITE_W-1:0]));
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      s1_r <= in_if.data;
    end
    if (fire_s1) begin
      out_r <= out_nxt;
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the exclusion ring update core
// A queue of pending commands feeds a clocked driver; a clocked monitor takes
// the results. An in-bench copy of the ring, defect and current counter
// predicts every result at the edge where its command is accepted, and the
// monitor compares each result field by field. A short directed run covers
// the ring edges, both bond crossings, rates at and above one and the unused
// command. Random phases then follow, each under new register settings.
// ----------------------------------------------------------------------------
module tb;
  import erd_pkg::*;

  localparam int RING = 512;
  localparam int GAP_MAX = 11;
  localparam int LONG_HOLD = 300;
  localparam int PHASE_ITEMS = 105;
  localparam int PHASES = 8;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Channel drive registers, known from time zero.
  logic feed_valid = 1'b0;
  in_item_t feed_data = '0;
  logic sink_ready = 1'b0;

  erd_stream_if #(.payload_t(in_item_t)) in_ch ();
  erd_stream_if #(.payload_t(out_item_t)) out_ch ();

  assign in_ch.valid = feed_valid;
  assign in_ch.data = feed_data;
  assign out_ch.ready = sink_ready;

  exclusion_ring_defect_mc_step_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data)
  );

  // Predicted ring state and register copies, at their reset values.
  logic [RING-1:0] ring_occ = '0;
  logic [SITE_W-1:0] defect_at = DEFECT_START_RST;
  logic [PERIOD_W-1:0] period_ctr = '0;
  logic signed [CUR_W-1:0] net_flow = '0;
  logic [RATE_W-1:0] rate_center_q = RATE_CENTER_RST;
  logic [RATE_W-1:0] rate_bulk_q = '0;
  logic [RATE_W-1:0] rate_far_in_q = '0;
  logic [RATE_W-1:0] rate_near_out_q = '0;
  logic [RATE_W-1:0] rate_near_in_q = '0;
  logic [PERIOD_W-1:0] period_q = DEFECT_PERIOD_RST;
  logic [SITE_W-1:0] bond_q = BOND_SITE_RST;
  logic [SITE_W-1:0] start_q = DEFECT_START_RST;

  in_item_t pending_items[$];
  out_item_t awaited_results[$];

  int mismatches = 0;
  int results_seen = 0;
  int feed_gap = 0;
  int sink_hold = 0;
  bit feed_calm = 1'b0;
  bit sink_calm = 1'b0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Apply one command to the predicted ring and return the result it yields.
  function automatic out_item_t advance_ring(in_item_t it);
    out_item_t res;
    logic [SITE_W-1:0] s, rt, lt, off;
    logic [RATE_W-1:0] rr, rl;
    logic fr, fl;
    logic [1:0] hop;
    hop = HOP_NONE;
    s = it.site;
    rt = s + 1'b1;
    lt = s - 1'b1;
    case (cmd_t'(it.cmd))
      CMD_LOAD: ring_occ[s] = it.occupy;
      CMD_CLEAR: begin
        net_flow = '0;
        period_ctr = '0;
        defect_at = start_q;
      end
      CMD_UPDATE: begin
        if (ring_occ[s]) begin
          // Rates depend on the offset of the site from the defect.
          off = s - defect_at;
          rr = rate_bulk_q;
          rl = rate_bulk_q;
          if (off == 0) begin
            rr = rate_center_q;
            rl = rate_center_q;
          end else if (off == SITE_W'(RING - 1)) begin
            rr = rate_near_in_q;
            rl = rate_near_out_q;
          end else if (off == SITE_W'(RING - 2)) begin
            rr = rate_far_in_q;
            rl = rate_bulk_q;
          end else if (off == 1) begin
            rr = rate_near_out_q;
            rl = rate_near_in_q;
          end else if (off == 2) begin
            rr = rate_bulk_q;
            rl = rate_far_in_q;
          end
          fr = !ring_occ[rt];
          fl = !ring_occ[lt];
          if (fr && fl) begin
            if (it.coin) begin
              if ({1'b0, it.draw} < rr) hop = HOP_RIGHT;
            end else if ({1'b0, it.draw} < rl) begin
              hop = HOP_LEFT;
            end
          end else if (fr) begin
            if (it.coin && {1'b0, it.draw} < rr) hop = HOP_RIGHT;
          end else if (fl) begin
            if (it.coin && {1'b0, it.draw} < rl) hop = HOP_LEFT;
          end
          // Move the particle and count crossings of the measuring bond.
          if (hop == HOP_RIGHT) begin
            ring_occ[s] = 1'b0;
            ring_occ[rt] = 1'b1;
            if (s == bond_q && net_flow != CUR_MAX) net_flow = net_flow + 1'b1;
          end else if (hop == HOP_LEFT) begin
            ring_occ[s] = 1'b0;
            ring_occ[lt] = 1'b1;
            if (s == SITE_W'(bond_q + 1'b1) && net_flow != CUR_MIN) net_flow = net_flow - 1'b1;
          end
        end
        period_ctr = period_ctr + 1'b1;
        if (period_ctr == period_q) begin
          defect_at = defect_at + 1'b1;
          period_ctr = '0;
        end
      end
      default: ;
    endcase
    res.hop = hop;
    res.net_current = net_flow;
    res.defect_pos = defect_at;
    return res;
  endfunction

  function automatic void queue_item(cmd_t c, logic [SITE_W-1:0] s, logic occ, logic cn,
                                     logic [DRAW_W-1:0] d);
    in_item_t it;
    it.cmd = c;
    it.site = s;
    it.occupy = occ;
    it.coin = cn;
    it.draw = d;
    pending_items.push_back(it);
  endfunction

  // One random phase: opens with a clear, then mostly updates and loads
  // aimed at the defect neighborhood and the measuring bond.
  function automatic void queue_random_phase(int n);
    logic [SITE_W-1:0] pos, s, jit;
    logic [PERIOD_W-1:0] cnt;
    logic [DRAW_W-1:0] d;
    cmd_t c;
    int r, k;
    pos = defect_at;
    cnt = period_ctr;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (k == 0) c = CMD_CLEAR;
      else if (r < 25) c = CMD_LOAD;
      else if (r < 93) c = CMD_UPDATE;
      else if (r < 96) c = CMD_CLEAR;
      else c = CMD_NONE;
      r = $urandom_range(0, 9);
      if (r < 4) begin
        jit = SITE_W'($urandom_range(0, 6));
        s = pos + jit - 3'd3;
      end else if (r < 6) begin
        jit = SITE_W'($urandom_range(0, 3));
        s = bond_q + jit - 1'b1;
      end else begin
        s = SITE_W'($urandom_range(0, RING - 1));
      end
      r = $urandom_range(0, 7);
      if (r == 0) d = '0;
      else if (r == 1) d = '1;
      else d = DRAW_W'($urandom_range(0, 65535));
      queue_item(c, s, $urandom_range(0, 9) < 7, 1'($urandom_range(0, 1)), d);
      // The defect path depends only on the command sequence.
      if (c == CMD_CLEAR) begin
        pos = start_q;
        cnt = '0;
      end else if (c == CMD_UPDATE) begin
        cnt = cnt + 1'b1;
        if (cnt == period_q) begin
          pos = pos + 1'b1;
          cnt = '0;
        end
      end
    end
  endfunction

  function automatic logic [RATE_W-1:0] pick_rate();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 17'd1;
      2: return 17'd65535;
      3: return 17'd65536;
      4: return '1;
      default: return RATE_W'($urandom_range(0, 65536));
    endcase
  endfunction

  // Register write, taken at the edge where cfg_we is high.
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_RATE_CENTER: rate_center_q = val;
      REG_RATE_BULK: rate_bulk_q = val;
      REG_RATE_FAR_INWARD: rate_far_in_q = val;
      REG_RATE_NEAR_OUTWARD: rate_near_out_q = val;
      REG_RATE_NEAR_INWARD: rate_near_in_q = val;
      REG_DEFECT_PERIOD: period_q = val[PERIOD_W-1:0];
      REG_BOND_SITE: bond_q = val[SITE_W-1:0];
      REG_DEFECT_START: start_q = val[SITE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] rc, rb, rfi, rno, rni, per, bond,
                              start);
    set_reg(REG_RATE_CENTER, rc);
    set_reg(REG_RATE_BULK, rb);
    set_reg(REG_RATE_FAR_INWARD, rfi);
    set_reg(REG_RATE_NEAR_OUTWARD, rno);
    set_reg(REG_RATE_NEAR_INWARD, rni);
    set_reg(REG_DEFECT_PERIOD, per);
    set_reg(REG_BOND_SITE, bond);
    set_reg(REG_DEFECT_START, start);
  endtask

  // Wait until every command is sent and every result is back, then let the
  // pipeline settle.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || feed_valid || awaited_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Driver: present pending commands with random gaps and predict each
  // accepted transaction.
  always @(posedge clk) begin : feed_items
    logic nv;
    in_item_t nd;
    if (!rst_n) begin
      feed_valid <= 1'b0;
      feed_gap = 0;
    end else begin
      nv = feed_valid;
      nd = feed_data;
      if (feed_valid && in_ch.ready) begin
        awaited_results.push_back(advance_ring(feed_data));
        nv = 1'b0;
        if ($urandom_range(0, 39) == 0) feed_calm = !feed_calm;
        feed_gap = feed_calm ? 0 : $urandom_range(0, GAP_MAX);
      end
      if (!nv) begin
        if (feed_gap != 0) begin
          feed_gap--;
        end else if (pending_items.size() != 0) begin
          nd = pending_items.pop_front();
          nv = 1'b1;
        end
      end
      feed_valid <= nv;
      feed_data <= nd;
    end
  end

  // Monitor: check each accepted result against the oldest prediction and
  // stall the result side at random, twice for a long stretch.
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst_n) begin
      sink_ready <= 1'b0;
      sink_hold = 0;
    end else begin
      if (out_ch.valid && sink_ready) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result: hop %0d, net_current %0d, defect_pos %0d", $time,
                   out_ch.data.hop, out_ch.data.net_current, out_ch.data.defect_pos);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          if (out_ch.data.hop !== want.hop) begin
            $display("%0t: hop mismatch: expected %0d, actual %0d", $time, want.hop,
                     out_ch.data.hop);
            mismatches++;
          end
          if (out_ch.data.net_current !== want.net_current) begin
            $display("%0t: net_current mismatch: expected %0d, actual %0d", $time,
                     want.net_current, out_ch.data.net_current);
            mismatches++;
          end
          if (out_ch.data.defect_pos !== want.defect_pos) begin
            $display("%0t: defect_pos mismatch: expected %0d, actual %0d", $time,
                     want.defect_pos, out_ch.data.defect_pos);
            mismatches++;
          end
        end
        if (results_seen % 400 == 150) begin
          sink_hold = LONG_HOLD;
        end else begin
          if ($urandom_range(0, 39) == 0) sink_calm = !sink_calm;
          sink_hold = sink_calm ? 0 : $urandom_range(0, GAP_MAX);
        end
      end
      if (sink_hold != 0) begin
        sink_hold--;
        sink_ready <= 1'b0;
      end else begin
        sink_ready <= 1'b1;
      end
    end
  end

  // Stimulus: reset, directed commands, then random phases.
  initial begin : stimulus
    logic [SITE_W-1:0] st, bd;
    int p;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: only the defect site can hop, at rate one.
    queue_item(CMD_LOAD, 9'd10, 1'b1, 1'b0, 16'd0);
    queue_item(CMD_LOAD, 9'd0, 1'b1, 1'b0, 16'd0);
    queue_item(CMD_LOAD, 9'd511, 1'b1, 1'b0, 16'd0);
    // Top draw still passes a rate of one.
    queue_item(CMD_UPDATE, 9'd10, 1'b0, 1'b1, 16'hFFFF);
    queue_item(CMD_UPDATE, 9'd11, 1'b0, 1'b0, 16'd0);
    // Empty site: no hop, but the period still counts.
    queue_item(CMD_UPDATE, 9'd300, 1'b1, 1'b1, 16'd0);
    // Only the right side is free and the coin is tails.
    queue_item(CMD_UPDATE, 9'd0, 1'b0, 1'b0, 16'd0);
    queue_item(CMD_NONE, 9'd511, 1'b1, 1'b1, 16'hFFFF);
    queue_item(CMD_CLEAR, 9'd0, 1'b0, 1'b0, 16'd0);
    wait_idle();

    // Bond at the ring end, defect near it, defect moving every update.
    program_regs('1, 17'd65536, 17'd65536, 17'd0, 17'd32768, 17'd1, 17'd511, 17'd509);
    queue_item(CMD_CLEAR, 9'd5, 1'b1, 1'b1, 16'hFFFF);
    queue_item(CMD_LOAD, 9'd0, 1'b0, 1'b0, 16'd0);
    queue_item(CMD_LOAD, 9'd511, 1'b1, 1'b0, 16'd0);
    // Right crossing over the wrapping bond, then the left crossing back.
    queue_item(CMD_UPDATE, 9'd511, 1'b0, 1'b1, 16'd0);
    queue_item(CMD_UPDATE, 9'd0, 1'b0, 1'b0, 16'hFFFF);
    // Rate above one at the defect site.
    queue_item(CMD_UPDATE, 9'd511, 1'b0, 1'b1, 16'hFFFF);
    queue_item(CMD_UPDATE, 9'd0, 1'b0, 1'b1, 16'd32767);
    queue_item(CMD_UPDATE, 9'd1, 1'b0, 1'b0, 16'd0);
    queue_item(CMD_UPDATE, 9'd0, 1'b0, 1'b1, 16'd100);
    queue_item(CMD_UPDATE, 9'd1, 1'b0, 1'b1, 16'd0);
    queue_item(CMD_UPDATE, 9'd2, 1'b0, 1'b1, 16'd1);
    queue_item(CMD_UPDATE, 9'd3, 1'b0, 1'b0, 16'd1);
    wait_idle();

    for (p = 0; p < PHASES; p++) begin
      if (p == 0) begin
        program_regs('1, '1, '1, '1, '1, 17'hFFFF, 17'd511, 17'd511);
      end else if (p == 1) begin
        program_regs('0, '0, '0, '0, '0, '0, '0, '0);
      end else begin
        st = SITE_W'($urandom_range(0, RING - 1));
        if ($urandom_range(0, 1) == 1) begin
          bd = SITE_W'($urandom_range(0, 4));
          bd = st + bd;
        end else begin
          bd = SITE_W'($urandom_range(0, RING - 1));
        end
        program_regs(pick_rate(), pick_rate(), pick_rate(), pick_rate(), pick_rate(),
                     ($urandom_range(0, 3) == 0) ? 17'd1 : 17'($urandom_range(1, 12)),
                     17'(bd), 17'(st));
      end
      queue_random_phase(PHASE_ITEMS);
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("exclusion_ring_defect_mc_step_core test passed");
    end else begin
      $display("exclusion_ring_defect_mc_step_core test failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2_000_000;
    $display("exclusion_ring_defect_mc_step_core test failed");
    $finish;
  end

endmodule

// ===== exclusion_ring_defect_mc_step_core.f =====
hdl/erd_pkg.sv
hdl/erd_stream_if.sv
hdl/exclusion_ring_defect_mc_step_core.sv
tb/tb.sv
